[sv/ict_pkg.sv]
// Shared types and constants of the inode cache table.
package ict_pkg;

	typedef enum logic [2:0] {
		OP_LOOKUP = 3'd0,
		OP_ALLOC  = 3'd1,
		OP_DUP    = 3'd2,
		OP_PUT    = 3'd3,
		OP_DIRTY  = 3'd4,
		OP_LOADED = 3'd5,
		OP_CLEAN  = 3'd6
	} op_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFREE  = 2'd1;
	localparam logic [1:0] STAT_PUTFREE = 2'd2;
	localparam logic [1:0] STAT_OVF     = 2'd3;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] dev;
		logic [31:0] ino;
		logic [15:0] refcnt;
		logic        dirty;
		logic        uptodate;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cnt_clr;
		logic cnt_inc;
		logic clear_wr;
		logic scan_rd;
		logic slot_rd;
		logic exec;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic scan_op;
	} ctl_sts_t;

endpackage

[sv/ict_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ict_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[sv/ict_ctrl.sv]
// Controller state machine of the inode cache table.
module ict_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ict_pkg::ctl_sts_t sts,
	output ict_pkg::ctl_cmd_t cmd
);
	import ict_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_READ  = 6'b010000,
		S_EXEC  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = sts.scan_op ? S_SCAN : S_READ;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EXEC;
			end
			S_READ: begin
				cmd.slot_rd = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

[sv/ict_datapath.sv]
// Datapath of the inode cache table: entry store, scan registers and update logic.
module ict_datapath #(
	parameter int ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ict_pkg::ctl_cmd_t cmd,
	output ict_pkg::ctl_sts_t sts,
	input  logic [2:0]        op,
	input  logic [15:0]       dev,
	input  logic [31:0]       ino,
	input  logic [5:0]        slot,
	output logic              done,
	output logic [5:0]        entry,
	output logic [1:0]        status,
	output logic              hit,
	output logic              needs_load,
	output logic              released,
	output logic [15:0]       count_after
);
	import ict_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int EW = $bits(entry_t);

	logic [2:0]    op_q;
	logic [15:0]   dev_q;
	logic [31:0]   ino_q;
	logic [5:0]    slot_q;
	logic [AW-1:0] cnt_q;

	logic          scan_v_s1;
	logic [AW-1:0] idx_s1;

	logic          match_q;
	logic [AW-1:0] match_idx_q;
	entry_t        match_ent_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [1:0]    free_bad_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_ent;

	logic          slot_ok;
	logic [AW-1:0] slot_addr;
	logic          is_match;
	logic          is_free;
	logic [1:0]    bad;

	logic          x_we;
	logic [AW-1:0] x_idx;
	entry_t        x_ent;
	logic [5:0]    x_entry;
	logic [1:0]    x_status;
	logic          x_hit;
	logic          x_load;
	logic          x_rel;
	logic [15:0]   x_count;

	assign rd_ent    = entry_t'(ram_rdata);
	assign slot_ok   = (32'(slot_q) < ENTRIES);
	assign slot_addr = AW'(slot_q);

	assign sts.last    = (cnt_q == AW'(ENTRIES - 1));
	assign sts.scan_op = op inside {OP_LOOKUP, OP_ALLOC};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			dev_q  <= dev;
			ino_q  <= ino;
			slot_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			scan_v_s1 <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			done      <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			scan_v_s1 <= cmd.scan_rd;
			done      <= cmd.exec;
			if (cmd.capture) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (scan_v_s1) begin
				if (is_match && !match_q) begin
					match_q <= 1'b1;
				end
				if (is_free && (!free_q || bad < free_bad_q)) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// The first match and the first free entry of least badness are kept.
	assign is_match = (op_q == OP_LOOKUP) && (rd_ent.dev == dev_q) && (rd_ent.ino == ino_q);
	assign is_free  = (rd_ent.refcnt == 16'd0);
	assign bad      = {rd_ent.dirty, rd_ent.uptodate};

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (scan_v_s1) begin
			if (is_match && !match_q) begin
				match_idx_q <= idx_s1;
				match_ent_q <= rd_ent;
			end
			if (is_free && (!free_q || bad < free_bad_q)) begin
				free_idx_q <= idx_s1;
				free_bad_q <= bad;
			end
		end
	end

	always_comb begin
		x_we     = 1'b0;
		x_idx    = slot_addr;
		x_ent    = rd_ent;
		x_entry  = 6'd0;
		x_status = STAT_OK;
		x_hit    = 1'b0;
		x_load   = 1'b0;
		x_rel    = 1'b0;
		x_count  = 16'd0;
		case (op_q)
			OP_LOOKUP, OP_ALLOC: begin
				if (match_q) begin
					x_we    = 1'b1;
					x_idx   = match_idx_q;
					x_ent   = match_ent_q;
					x_entry = 6'(match_idx_q);
					x_hit   = 1'b1;
					x_load  = !match_ent_q.uptodate;
					if (match_ent_q.refcnt == COUNT_MAX) begin
						x_status = STAT_OVF;
					end else begin
						x_ent.refcnt = match_ent_q.refcnt + 16'd1;
					end
					x_count = x_ent.refcnt;
				end else if (free_q) begin
					x_we           = 1'b1;
					x_idx          = free_idx_q;
					x_ent.refcnt   = 16'd1;
					x_ent.dirty    = 1'b0;
					x_ent.uptodate = 1'b0;
					x_ent.dev      = (op_q == OP_LOOKUP) ? dev_q : 16'd0;
					x_ent.ino      = (op_q == OP_LOOKUP) ? ino_q : 32'd0;
					x_entry        = 6'(free_idx_q);
					x_load         = (op_q == OP_LOOKUP);
					x_count        = 16'd1;
				end else begin
					x_status = STAT_NOFREE;
				end
			end
			OP_DUP, OP_PUT, OP_DIRTY, OP_LOADED, OP_CLEAN: begin
				x_entry = slot_q;
				if (slot_ok) begin
					x_we = 1'b1;
					case (op_q)
						OP_DUP: begin
							if (rd_ent.refcnt == COUNT_MAX) begin
								x_status = STAT_OVF;
							end else begin
								x_ent.refcnt = rd_ent.refcnt + 16'd1;
							end
						end
						OP_PUT: begin
							if (rd_ent.refcnt == 16'd0) begin
								x_status = STAT_PUTFREE;
							end else begin
								x_ent.refcnt = rd_ent.refcnt - 16'd1;
								x_rel        = (rd_ent.refcnt == 16'd1);
							end
						end
						OP_DIRTY: begin
							x_ent.dirty = 1'b1;
						end
						OP_LOADED: begin
							x_ent.uptodate = 1'b1;
						end
						default: begin
							x_ent.dirty = 1'b0;
						end
					endcase
					x_count = x_ent.refcnt;
				end
			end
			default: begin
				x_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			entry       <= x_entry;
			status      <= x_status;
			hit         <= x_hit;
			needs_load  <= x_load;
			released    <= x_rel;
			count_after <= x_count;
		end
	end

	// The clearing pass after reset writes zeros through the counter.
	assign ram_we    = cmd.clear_wr || (cmd.exec && x_we);
	assign ram_waddr = cmd.clear_wr ? cnt_q : x_idx;
	assign ram_wdata = cmd.clear_wr ? '0 : EW'(x_ent);
	assign ram_re    = cmd.scan_rd || cmd.slot_rd;
	assign ram_raddr = cmd.scan_rd ? cnt_q : slot_addr;

	ict_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule

[sv/inode_cache_table.sv]
// Top level of the inode cache table: controller and datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  request  | start / busy       | op, dev, ino, slot
//  result   | done (one cycle)   | entry, status, hit, needs_load, released, count_after
//
// After reset a clearing pass writes every entry to zero; busy is high until it ends.
// Lookup and anonymous alloc scan the store one entry a cycle through its single read
// port; busy stays high through the scan, a drain state and an execute state, and done
// is registered from the execute state. Dup, put and the flag operations read one entry
// and write it back through a read and an execute state; the next request waits for idle.
// The receiver cannot stall: done lasts one cycle and must be taken then.
module inode_cache_table #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [15:0] dev,
	input  logic [31:0] ino,
	input  logic [5:0]  slot,
	output logic        done,
	output logic [5:0]  entry,
	output logic [1:0]  status,
	output logic        hit,
	output logic        needs_load,
	output logic        released,
	output logic [15:0] count_after
);
	import ict_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ict_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	ict_datapath #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.dev        (dev),
		.ino        (ino),
		.slot       (slot),
		.done       (done),
		.entry      (entry),
		.status     (status),
		.hit        (hit),
		.needs_load (needs_load),
		.released   (released),
		.count_after(count_after)
	);

	// A result only follows a cycle in which the block was working on a request.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not make the block busy");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NOFREE) |-> (entry == 6'd0 && count_after == 16'd0 && !hit))
		else $error("no-free result carries non-zero fields");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (count_after != 16'd0))
		else $error("hit with zero reference count");

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && released) |-> (count_after == 16'd0 && status == STAT_OK))
		else $error("release with non-zero count or error status");
endmodule
